// ===== design/bshd_pkg.sv =====
// Shared constants, types and codes for the byte string hash dictionary.
package bshd_pkg;

  localparam int unsigned TableSlots  = 4096;
  localparam int unsigned TextBytes   = 65536;
  localparam int unsigned MaxKeyBytes = 64;
  localparam int unsigned MaxEntries  = 2048;

  localparam int unsigned IdxW   = $clog2(TableSlots);
  localparam int unsigned ProbeW = $clog2(TableSlots + 1);
  localparam int unsigned TaddrW = $clog2(TextBytes);
  localparam int unsigned FillW  = $clog2(TextBytes + 1);
  localparam int unsigned KlenW  = $clog2(MaxKeyBytes + 2);
  localparam int unsigned KaddrW = (MaxKeyBytes > 1) ? $clog2(MaxKeyBytes) : 1;
  localparam int unsigned IdW    = 12;
  localparam int unsigned StW    = 3;

  localparam logic [63:0] HashBasis = 64'd1469598103934665603;

  typedef enum logic [StW-1:0] {
    ST_FOUND    = 3'd0,
    ST_ADDED    = 3'd1,
    ST_ABSENT   = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [TaddrW-1:0] off;
    logic [KlenW-1:0]  len;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [KlenW-1:0] len;
    logic             first;
    logic             too_long;
  } key_info_t;

endpackage

// ===== design/bshd_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module bshd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ===== design/bshd_hash.sv =====
// FNV-1a style hash (non-standard offset basis) and key length accumulator, one byte per en_i cycle.
module bshd_hash (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                last_i,
  input  logic [7:0]          byte_i,
  output bshd_pkg::key_info_t info_o
);

  logic [63:0]                hash_q, hash_d, mixed, prod;
  logic [bshd_pkg::KlenW-1:0] len_q, len_d, len_nxt;

  // prime = 2^40 + 0x1b3
  assign mixed = hash_q ^ {56'd0, byte_i};
  assign prod  = (mixed << 40) + (mixed * 64'd435);

  assign len_nxt = (len_q <= bshd_pkg::KlenW'(bshd_pkg::MaxKeyBytes)) ?
                   len_q + 1'b1 : len_q;

  assign info_o.idx      = prod[bshd_pkg::IdxW-1:0];
  assign info_o.len      = len_nxt;
  assign info_o.first    = (len_q == '0);
  assign info_o.too_long = (len_nxt > bshd_pkg::KlenW'(bshd_pkg::MaxKeyBytes));

  always_comb begin
    hash_d = hash_q;
    len_d  = len_q;
    if (en_i) begin
      hash_d = last_i ? bshd_pkg::HashBasis : prod;
      len_d  = last_i ? '0 : len_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= bshd_pkg::HashBasis;
      len_q  <= '0;
    end else begin
      hash_q <= hash_d;
      len_q  <= len_d;
    end
  end

endmodule

// ===== design/byte_string_hash_dictionary.sv =====
// Top level: hash dictionary controller with slot, text and key memories.
// Sequence: key bytes are taken one per cycle while busy is low; after the last byte, probed
//   slots are read and checked, equal-length keys compared byte by byte, and on add the key
//   copied to text. A key over the length limit answers in the cycle after its last byte.
// Throughput: one byte per cycle until the last byte; busy is high during probe, compare and copy.
// Reset: a sweep over all 4096 slots clears the slot table; busy stays high meanwhile.
// Results are strobed by valid_o for one cycle; the receiver cannot stall.
module byte_string_hash_dictionary (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [7:0]  key_byte_i,
  input  logic        key_last_i,
  output logic        valid_o,
  output logic [11:0] token_id_o,
  output logic [2:0]  status_o
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_RDSLOT = 8'b0000_0100,
    S_CHKSLT = 8'b0000_1000,
    S_RDCMP  = 8'b0001_0000,
    S_CHKCMP = 8'b0010_0000,
    S_RDCP   = 8'b0100_0000,
    S_WRCP   = 8'b1000_0000
  } state_e;

  state_e                          state_q, state_d;
  logic [bshd_pkg::IdxW-1:0]       idx_q, idx_d;
  logic [bshd_pkg::ProbeW-1:0]     probes_q, probes_d;
  logic [bshd_pkg::KlenW-1:0]      klen_q, klen_d, k_q, k_d;
  logic                            req_q, req_d;
  logic [bshd_pkg::IdW-1:0]        count_q, count_d;
  logic [bshd_pkg::FillW-1:0]      fill_q, fill_d;
  bshd_pkg::slot_t                 slot_q, slot_d, slot_rd, slot_wr;
  logic                            valid_q, valid_d;
  logic [bshd_pkg::IdW-1:0]        tok_q, tok_d;
  bshd_pkg::status_e               st_q, st_d;

  logic                            accept, advance, req_eff;
  bshd_pkg::key_info_t             info;
  logic                            slot_we, text_we, kb_we;
  logic [bshd_pkg::TaddrW-1:0]     text_addr;
  logic [7:0]                      text_rd, kb_rd, kb_wdata;
  logic [bshd_pkg::KaddrW-1:0]     kb_addr;
  logic [bshd_pkg::FillW:0]        fill_end;

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign req_eff = info.first ? req_type_i : req_q;

  bshd_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .last_i (key_last_i),
    .byte_i (key_byte_i),
    .info_o (info)
  );

  bshd_ram #(.Width(bshd_pkg::SlotW), .Depth(bshd_pkg::TableSlots)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .addr_i  (idx_q),
    .wdata_i (slot_wr),
    .rdata_o (slot_rd)
  );

  bshd_ram #(.Width(8), .Depth(bshd_pkg::TextBytes)) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (text_we),
    .addr_i  (text_addr),
    .wdata_i (kb_rd),
    .rdata_o (text_rd)
  );

  bshd_ram #(.Width(8), .Depth(bshd_pkg::MaxKeyBytes)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (kb_we),
    .addr_i  (kb_addr),
    .wdata_i (kb_wdata),
    .rdata_o (kb_rd)
  );

  assign fill_end = {1'b0, fill_q} + (bshd_pkg::FillW+1)'(klen_q);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    probes_d = probes_q;
    klen_d   = klen_q;
    k_d      = k_q;
    req_d    = req_q;
    count_d  = count_q;
    fill_d   = fill_q;
    slot_d   = slot_q;
    valid_d  = 1'b0;
    tok_d    = tok_q;
    st_d     = st_q;
    slot_we  = 1'b0;
    slot_wr  = '0;
    text_we  = 1'b0;
    text_addr = slot_q.off + bshd_pkg::TaddrW'(k_q);
    kb_we    = 1'b0;
    kb_addr  = k_q[bshd_pkg::KaddrW-1:0];
    kb_wdata = key_byte_i;
    advance  = 1'b0;

    case (state_q)
      S_CLEAR: begin
        slot_we = 1'b1;
        idx_d   = idx_q + 1'b1;
        if (idx_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        kb_addr = info.len[bshd_pkg::KaddrW-1:0] - 1'b1;
        if (accept) begin
          kb_we = !info.too_long;
          if (info.first) begin
            req_d = req_type_i;
          end
          if (key_last_i) begin
            if (info.too_long) begin
              valid_d = 1'b1;
              tok_d   = '0;
              st_d    = req_eff ? bshd_pkg::ST_TOO_LONG : bshd_pkg::ST_ABSENT;
            end else begin
              req_d    = req_eff;
              klen_d   = info.len;
              idx_d    = info.idx;
              probes_d = '0;
              state_d  = S_RDSLOT;
            end
          end
        end
      end
      S_RDSLOT: begin
        state_d = S_CHKSLT;
      end
      S_CHKSLT: begin
        slot_d = slot_rd;
        k_d    = '0;
        if (slot_rd.id == '0) begin
          valid_d = 1'b1;
          tok_d   = '0;
          state_d = S_IDLE;
          if (!req_q) begin
            st_d = bshd_pkg::ST_ABSENT;
          end else if (count_q >= bshd_pkg::IdW'(bshd_pkg::MaxEntries) ||
                       fill_end > (bshd_pkg::FillW+1)'(bshd_pkg::TextBytes)) begin
            st_d = bshd_pkg::ST_FULL;
          end else begin
            valid_d = 1'b0;
            state_d = S_RDCP;
          end
        end else if (slot_rd.len == klen_q) begin
          state_d = S_RDCMP;
        end else begin
          advance = 1'b1;
        end
      end
      S_RDCMP: begin
        state_d = S_CHKCMP;
      end
      S_CHKCMP: begin
        if (text_rd != kb_rd) begin
          advance = 1'b1;
        end else if (k_q + 1'b1 == klen_q) begin
          valid_d = 1'b1;
          tok_d   = slot_q.id;
          st_d    = bshd_pkg::ST_FOUND;
          state_d = S_IDLE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_RDCMP;
        end
      end
      S_RDCP: begin
        state_d = S_WRCP;
      end
      S_WRCP: begin
        text_we   = 1'b1;
        text_addr = fill_q[bshd_pkg::TaddrW-1:0] + bshd_pkg::TaddrW'(k_q);
        if (k_q + 1'b1 == klen_q) begin
          slot_we     = 1'b1;
          slot_wr.id  = count_q + 1'b1;
          slot_wr.off = fill_q[bshd_pkg::TaddrW-1:0];
          slot_wr.len = klen_q;
          count_d     = count_q + 1'b1;
          fill_d      = fill_end[bshd_pkg::FillW-1:0];
          valid_d     = 1'b1;
          tok_d       = count_q + 1'b1;
          st_d        = bshd_pkg::ST_ADDED;
          state_d     = S_IDLE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_RDCP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (advance) begin
      idx_d    = idx_q + 1'b1;
      probes_d = probes_q + 1'b1;
      if (probes_q + 1'b1 == bshd_pkg::ProbeW'(bshd_pkg::TableSlots)) begin
        valid_d = 1'b1;
        tok_d   = '0;
        st_d    = req_q ? bshd_pkg::ST_FULL : bshd_pkg::ST_ABSENT;
        state_d = S_IDLE;
      end else begin
        state_d = S_RDSLOT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      idx_q    <= '0;
      probes_q <= '0;
      klen_q   <= '0;
      k_q      <= '0;
      req_q    <= 1'b0;
      count_q  <= '0;
      fill_q   <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      probes_q <= probes_d;
      klen_q   <= klen_d;
      k_q      <= k_d;
      req_q    <= req_d;
      count_q  <= count_d;
      fill_q   <= fill_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    tok_q  <= tok_d;
    st_q   <= st_d;
  end

  assign valid_o    = valid_q;
  assign token_id_o = tok_q;
  assign status_o   = st_q;

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> state_q == S_IDLE)
    else $error("result strobe outside idle");

  a_added_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && st_q == bshd_pkg::ST_ADDED) |-> tok_q != '0)
    else $error("added entry without id");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bshd_pkg::IdW'(bshd_pkg::MaxEntries))
    else $error("entry count over limit");

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHKCMP || state_q == S_WRCP) |-> k_q < klen_q)
    else $error("byte index past key length");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(state_q == S_WRCP))
    else $error("entry count moved outside add");

endmodule

// ===== test/tb_byte_string_hash_dictionary.sv =====
// Testbench for the byte string hash dictionary: directed and random keys checked against a predictor.
module tb_byte_string_hash_dictionary;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned   NumItems   = 1080;
  localparam int unsigned   CycleLimit = 4000000;
  localparam int unsigned   DrainWait  = 300;
  localparam int unsigned   PoolSize   = 32;
  localparam logic [63:0]   FnvPrime   = 64'd1099511628211;

  typedef struct {
    logic [bshd_pkg::IdW-1:0] id;
    bshd_pkg::status_e        st;
  } answer_t;

  typedef struct {
    logic                     rq;
    logic [7:0]               kb;
    logic                     kl;
    logic                     typed;
    logic [bshd_pkg::IdW-1:0] id;
    bshd_pkg::status_e        st;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        req_type_i;
  logic [7:0]  key_byte_i;
  logic        key_last_i;
  logic        valid_o;
  logic [11:0] token_id_o;
  logic [2:0]  status_o;

  byte_string_hash_dictionary u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_type_i (req_type_i),
    .key_byte_i (key_byte_i),
    .key_last_i (key_last_i),
    .valid_o    (valid_o),
    .token_id_o (token_id_o),
    .status_o   (status_o)
  );

  // dictionary mirror
  logic [bshd_pkg::IdW-1:0]    slot_id  [bshd_pkg::TableSlots];
  logic [bshd_pkg::TaddrW-1:0] slot_off [bshd_pkg::TableSlots];
  int unsigned                 slot_len [bshd_pkg::TableSlots];
  logic [7:0]                  text_mem [bshd_pkg::TextBytes];
  logic [7:0]                  key_mem  [bshd_pkg::MaxKeyBytes];
  logic [63:0]                 run_hash;
  int unsigned                 key_len;
  int unsigned                 entries;
  int unsigned                 text_fill;
  logic                        req_held;

  answer_t     pending_answers[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  logic        idle_on;

  logic [7:0]  pool_key [PoolSize][66];
  int unsigned pool_len [PoolSize];

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && valid_o) begin
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transaction: id %0d status %0d", token_id_o, status_o);
      end else begin
        want = pending_answers.pop_front();
        if (token_id_o !== want.id || status_o !== want.st) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected id %0d status %0d, got id %0d status %0d",
                     want.id, want.st, token_id_o, status_o);
        end
      end
    end
  end

  function automatic logic key_equal(int unsigned s, int unsigned len);
    if (slot_len[s] != len) return 1'b0;
    for (int unsigned k = 0; k < len; k++)
      if (text_mem[slot_off[s] + k] != key_mem[k]) return 1'b0;
    return 1'b1;
  endfunction

  // Advances the mirror by one key byte; returns 1 with the answer on a final byte.
  function automatic logic dict_apply(input logic rq, input logic [7:0] kb, input logic kl,
                                      output answer_t ans);
    int unsigned idx;
    int unsigned len;
    logic        hit;
    logic        empty;
    if (key_len == 0) req_held = rq;
    run_hash = (run_hash ^ {56'd0, kb}) * FnvPrime;
    if (key_len < bshd_pkg::MaxKeyBytes) key_mem[key_len] = kb;
    if (key_len <= bshd_pkg::MaxKeyBytes) key_len++;
    if (!kl) return 1'b0;
    len = key_len;
    ans.id = '0;
    hit = 1'b0;
    empty = 1'b0;
    if (len > bshd_pkg::MaxKeyBytes) begin
      ans.st = req_held ? bshd_pkg::ST_TOO_LONG : bshd_pkg::ST_ABSENT;
    end else begin
      idx = 32'(run_hash[bshd_pkg::IdxW-1:0]);
      for (int unsigned p = 0; p < bshd_pkg::TableSlots; p++) begin
        if (slot_id[idx] == 0) begin
          empty = 1'b1;
          break;
        end
        if (key_equal(idx, len)) begin
          hit = 1'b1;
          break;
        end
        idx = (idx + 1) % bshd_pkg::TableSlots;
      end
      if (hit) begin
        ans.id = slot_id[idx];
        ans.st = bshd_pkg::ST_FOUND;
      end else if (!req_held) begin
        ans.st = bshd_pkg::ST_ABSENT;
      end else if (!empty || entries >= bshd_pkg::MaxEntries ||
                   text_fill > bshd_pkg::TextBytes - len) begin
        ans.st = bshd_pkg::ST_FULL;
      end else begin
        for (int unsigned k = 0; k < len; k++) text_mem[text_fill + k] = key_mem[k];
        slot_off[idx] = bshd_pkg::TaddrW'(text_fill);
        slot_len[idx] = len;
        entries++;
        slot_id[idx] = bshd_pkg::IdW'(entries);
        text_fill += len;
        ans.id = bshd_pkg::IdW'(entries);
        ans.st = bshd_pkg::ST_ADDED;
      end
    end
    run_hash = bshd_pkg::HashBasis;
    key_len  = 0;
    req_held = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_byte(input logic rq, input logic [7:0] kb, input logic kl,
                           input logic typed = 1'b0, input logic [bshd_pkg::IdW-1:0] tid = '0,
                           input bshd_pkg::status_e tst = bshd_pkg::ST_FOUND);
    answer_t     ans;
    int unsigned gap;
    start      <= 1'b1;
    req_type_i <= rq;
    key_byte_i <= kb;
    key_last_i <= kl;
    do @(posedge clk_i); while (busy);
    if (dict_apply(rq, kb, kl, ans)) begin
      if (typed) begin
        ans.id = tid;
        ans.st = tst;
      end
      pending_answers.push_back(ans);
    end
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_key(input logic rq, input int unsigned slot, input logic typed = 1'b0,
                          input logic [bshd_pkg::IdW-1:0] tid = '0,
                          input bshd_pkg::status_e tst = bshd_pkg::ST_FOUND);
    for (int unsigned k = 0; k < pool_len[slot]; k++) begin
      if (k == pool_len[slot] - 1)
        send_byte(k == 0 ? rq : 1'($urandom_range(0, 1)), pool_key[slot][k], 1'b1,
                  typed, tid, tst);
      else
        send_byte(k == 0 ? rq : 1'($urandom_range(0, 1)), pool_key[slot][k], 1'b0);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic void make_key(int unsigned slot, int unsigned len);
    logic [7:0] alpha;
    alpha = $urandom_range(0, 3) == 0 ? 8'hFF : 8'h07;
    pool_len[slot] = len;
    for (int unsigned k = 0; k < len; k++) pool_key[slot][k] = 8'($urandom()) & alpha;
  endfunction

  stim_row_t directed[] = '{
    '{1'b0, 8'h00, 1'b1, 1'b1, 12'd0, bshd_pkg::ST_ABSENT},
    '{1'b1, 8'h00, 1'b1, 1'b1, 12'd1, bshd_pkg::ST_ADDED},
    '{1'b0, 8'h00, 1'b1, 1'b1, 12'd1, bshd_pkg::ST_FOUND},
    '{1'b1, 8'hFF, 1'b1, 1'b1, 12'd2, bshd_pkg::ST_ADDED},
    '{1'b1, 8'hFF, 1'b1, 1'b1, 12'd2, bshd_pkg::ST_FOUND},
    '{1'b1, 8'h41, 1'b0, 1'b0, 12'd0, bshd_pkg::ST_FOUND},
    '{1'b0, 8'h42, 1'b1, 1'b1, 12'd3, bshd_pkg::ST_ADDED},
    '{1'b0, 8'h41, 1'b0, 1'b0, 12'd0, bshd_pkg::ST_FOUND},
    '{1'b1, 8'h42, 1'b1, 1'b1, 12'd3, bshd_pkg::ST_FOUND},
    '{1'b0, 8'h42, 1'b0, 1'b0, 12'd0, bshd_pkg::ST_FOUND},
    '{1'b1, 8'h41, 1'b1, 1'b0, 12'd0, bshd_pkg::ST_FOUND},
    '{1'b1, 8'h55, 1'b1, 1'b0, 12'd0, bshd_pkg::ST_FOUND},
    '{1'b0, 8'hAA, 1'b1, 1'b0, 12'd0, bshd_pkg::ST_FOUND}
  };

  initial begin
    int unsigned sent;
    int unsigned slot;
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_type_i = 1'b0;
    key_byte_i = '0;
    key_last_i = 1'b0;
    idle_on    = 1'b1;
    for (int unsigned s = 0; s < bshd_pkg::TableSlots; s++) begin
      slot_id[s]  = '0;
      slot_off[s] = '0;
      slot_len[s] = 0;
    end
    run_hash  = bshd_pkg::HashBasis;
    key_len   = 0;
    entries   = 0;
    text_fill = 0;
    req_held  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      send_byte(directed[i].rq, directed[i].kb, directed[i].kl,
                directed[i].typed, directed[i].id, directed[i].st);

    // longest legal key, then over-long keys
    make_key(0, bshd_pkg::MaxKeyBytes);
    send_key(1'b1, 0);
    send_key(1'b0, 0);
    make_key(1, bshd_pkg::MaxKeyBytes + 1);
    send_key(1'b1, 1, 1'b1, 12'd0, bshd_pkg::ST_TOO_LONG);
    make_key(1, bshd_pkg::MaxKeyBytes + 2);
    send_key(1'b0, 1, 1'b1, 12'd0, bshd_pkg::ST_ABSENT);
    drain();

    for (int unsigned p = 0; p < PoolSize; p++) make_key(p, $urandom_range(1, 6));
    sent = 0;
    while (sent < NumItems) begin
      if (sent % 200 < 40) idle_on = 1'b0;
      else idle_on = 1'b1;
      slot = $urandom_range(0, PoolSize - 1);
      case ($urandom_range(0, 9))
        0: make_key(slot, $urandom_range(bshd_pkg::MaxKeyBytes - 2, bshd_pkg::MaxKeyBytes + 2));
        1, 2, 3: make_key(slot, $urandom_range(1, 10));
        default: ;
      endcase
      send_key(1'($urandom_range(0, 1)), slot);
      sent += pool_len[slot];
      if ($urandom_range(0, 40) == 0) drain();
    end
    drain();

    idle_on = 1'b1;
    send_byte(1'b0, 8'hFF, 1'b1, 1'b1, 12'd2, bshd_pkg::ST_FOUND);
    start <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
